### rtl/cone_support_point_core_defines.svh
// Assertion macros for the cone support point RTL.
`ifndef CONE_SUPPORT_POINT_CORE_DEFINES_SVH
`define CONE_SUPPORT_POINT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CSP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cone support point check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define CSP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cone support point check failed");

`endif

### rtl/csp_pkg.sv
// Shared constants, register codes and lane types of the cone support point core.
package csp_pkg;

   localparam int WORD_WIDTH   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int SQ_WIDTH     = 2 * WORD_WIDTH;
   localparam int ROOT_WIDTH   = WORD_WIDTH;
   localparam int REM_WIDTH    = ROOT_WIDTH + 2;
   localparam int SQRT_STEPS   = SQ_WIDTH / 2;
   localparam int RADIUS_WIDTH = 31;
   localparam int QH_WIDTH     = 30;
   localparam int SIN_WIDTH    = 17;
   localparam int EPS_WIDTH    = 16;
   localparam int QUOT_WIDTH   = RADIUS_WIDTH;
   localparam int DIV_STEPS    = QUOT_WIDTH;
   localparam int PROD_WIDTH   = WORD_WIDTH + RADIUS_WIDTH;
   localparam int T_WIDTH      = ROOT_WIDTH + SIN_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int FEAT_WIDTH   = 2;

   localparam logic [WORD_WIDTH-1:0] POS_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOTTOM_RADIUS  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUARTER_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIN_ANGLE      = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EPSILON        = 2'd3;

   localparam logic [FEAT_WIDTH-1:0] FEAT_APEX   = 2'd0;
   localparam logic [FEAT_WIDTH-1:0] FEAT_RIM    = 2'd1;
   localparam logic [FEAT_WIDTH-1:0] FEAT_CENTRE = 2'd2;

   typedef struct packed {
      logic [SQ_WIDTH-1:0]   rad;
      logic [REM_WIDTH-1:0]  rem;
      logic [ROOT_WIDTH-1:0] root;
   } sqrt_lane_type;

   typedef struct packed {
      logic [ROOT_WIDTH-1:0] rem;
      logic [QUOT_WIDTH-1:0] low;
      logic [QUOT_WIDTH-1:0] quot;
   } div_lane_type;

   typedef struct packed {
      logic                  nx;
      logic                  nz;
      logic                  pos;
      logic [WORD_WIDTH-1:0] mx;
      logic [WORD_WIDTH-1:0] my;
      logic [WORD_WIDTH-1:0] mz;
   } dir_side_type;

   typedef struct packed {
      logic [FEAT_WIDTH-1:0] feature;
      logic                  nx;
      logic                  nz;
      logic [ROOT_WIDTH-1:0] s;
   } div_side_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] point_x;
      logic [WORD_WIDTH-1:0] point_y;
      logic [WORD_WIDTH-1:0] point_z;
      logic [FEAT_WIDTH-1:0] feature;
   } result_type;

endpackage

### rtl/csp_sqrt_cell.sv
// One digit cell of the square root chain: two radicand bits in, one root bit out.
module csp_sqrt_cell (
   input  logic                   clock,
   input  logic                   en,
   input  csp_pkg::sqrt_lane_type src,
   output csp_pkg::sqrt_lane_type dst
);

   logic [csp_pkg::REM_WIDTH+1:0] part;
   logic [csp_pkg::REM_WIDTH+1:0] trial;
   logic [csp_pkg::REM_WIDTH+1:0] diff;
   logic                          ge;
   csp_pkg::sqrt_lane_type        lane_in;
   csp_pkg::sqrt_lane_type        lane_ff;

   always_comb begin
      part  = {src.rem, src.rad[csp_pkg::SQ_WIDTH-1 -: 2]};
      trial = {2'b00, src.root, 2'b01};
      diff  = part - trial;
      ge    = (part >= trial);
      lane_in.rad  = {src.rad[csp_pkg::SQ_WIDTH-3:0], 2'b00};
      lane_in.rem  = ge ? diff[csp_pkg::REM_WIDTH-1:0] : part[csp_pkg::REM_WIDTH-1:0];
      lane_in.root = {src.root[csp_pkg::ROOT_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign dst = lane_ff;

endmodule

### rtl/csp_div_cell.sv
// One restoring division cell: one quotient bit per cell.
module csp_div_cell (
   input  logic                            clock,
   input  logic                            en,
   input  logic [csp_pkg::ROOT_WIDTH-1:0]  divisor,
   input  csp_pkg::div_lane_type           src,
   output csp_pkg::div_lane_type           dst
);

   logic [csp_pkg::ROOT_WIDTH:0] part;
   logic [csp_pkg::ROOT_WIDTH:0] diff;
   logic                         ge;
   csp_pkg::div_lane_type        lane_in;
   csp_pkg::div_lane_type        lane_ff;

   always_comb begin
      part = {src.rem, src.low[csp_pkg::QUOT_WIDTH-1]};
      diff = part - {1'b0, divisor};
      ge   = (part >= {1'b0, divisor});
      lane_in.rem  = ge ? diff[csp_pkg::ROOT_WIDTH-1:0] : part[csp_pkg::ROOT_WIDTH-1:0];
      lane_in.low  = {src.low[csp_pkg::QUOT_WIDTH-2:0], 1'b0};
      lane_in.quot = {src.quot[csp_pkg::QUOT_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign dst = lane_ff;

endmodule

### rtl/csp_out_buf.sv
// Two-entry result buffer; full flag is decoded from the registered count.
module csp_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csp_pkg::result_type push_data,
   input  logic                pop_ready,
   output logic                full,
   output logic                head_valid,
   output csp_pkg::result_type head
);

   logic [1:0]          count_ff;
   logic [1:0]          count_in;
   csp_pkg::result_type slot0_ff;
   csp_pkg::result_type slot1_ff;
   logic                pop;

   assign pop        = head_valid && pop_ready;
   assign head_valid = (count_ff != 2'd0);
   assign full       = (count_ff == 2'd2);
   assign head       = slot0_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !push) begin
         slot0_ff <= slot1_ff;
      end else if (push && pop) begin
         slot0_ff <= push_data;
      end else if (push && count_ff == 2'd0) begin
         slot0_ff <= push_data;
      end
      if (push && !pop && count_ff == 2'd1) begin
         slot1_ff <= push_data;
      end
   end

endmodule

### rtl/cone_support_point_core.sv
// Cone support point core: pipelined support mapping of a y-axis cone.
// Takes one direction transfer per cycle while the result buffer is not full and
// returns the farthest cone point for each, in order. The path runs through the
// 32-cell square root chain (one root bit per cell, norm and radial length
// side by side) and the 31-cell divider chain (one quotient bit per cell,
// x and z side by side), plus four front stages, one multiply stage and a
// two-entry result buffer. The whole pipe halts only when that buffer is full.
// Configuration writes take effect at once and are meant for an idle core.
`include "cone_support_point_core_defines.svh"

module cone_support_point_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [csp_pkg::WORD_WIDTH-1:0]      req_dir_x,
   input  logic [csp_pkg::WORD_WIDTH-1:0]      req_dir_y,
   input  logic [csp_pkg::WORD_WIDTH-1:0]      req_dir_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [csp_pkg::WORD_WIDTH-1:0]      rsp_point_x,
   output logic [csp_pkg::WORD_WIDTH-1:0]      rsp_point_y,
   output logic [csp_pkg::WORD_WIDTH-1:0]      rsp_point_z,
   output logic [csp_pkg::FEAT_WIDTH-1:0]      rsp_feature,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [csp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [csp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int W  = csp_pkg::WORD_WIDTH;
   localparam int NS = csp_pkg::SQRT_STEPS;
   localparam int ND = csp_pkg::DIV_STEPS;

   // configuration
   logic [csp_pkg::RADIUS_WIDTH-1:0] bottom_radius_ff;
   logic [csp_pkg::QH_WIDTH-1:0]     quarter_height_ff;
   logic [csp_pkg::SIN_WIDTH-1:0]    sin_angle_ff;
   logic [csp_pkg::EPS_WIDTH-1:0]    epsilon_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_radius_ff  <= csp_pkg::RADIUS_WIDTH'(65536);
         quarter_height_ff <= csp_pkg::QH_WIDTH'(16384);
         sin_angle_ff      <= csp_pkg::SIN_WIDTH'(46341);
         epsilon_ff        <= csp_pkg::EPS_WIDTH'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            csp_pkg::CSR_BOTTOM_RADIUS: begin
               bottom_radius_ff <= csr_wdata[csp_pkg::RADIUS_WIDTH-1:0];
            end
            csp_pkg::CSR_QUARTER_HEIGHT: begin
               quarter_height_ff <= csr_wdata[csp_pkg::QH_WIDTH-1:0];
            end
            csp_pkg::CSR_SIN_ANGLE: begin
               sin_angle_ff <= csr_wdata[csp_pkg::SIN_WIDTH-1:0];
            end
            csp_pkg::CSR_EPSILON: begin
               epsilon_ff <= csr_wdata[csp_pkg::EPS_WIDTH-1:0];
            end
         endcase
      end
   end

   // pipe control
   logic                buf_full;
   logic                en;
   logic                push;
   csp_pkg::result_type res;
   csp_pkg::result_type head;

   assign en        = !buf_full;
   assign req_ready = en;

   // front: magnitudes, squares, sums
   csp_pkg::dir_side_type s0_side_in;
   csp_pkg::dir_side_type s0_side_ff, s1_side_ff, s2_side_ff, s3_side_ff;
   logic                  s0_vld_ff, s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [csp_pkg::SQ_WIDTH-1:0] sqx_ff, sqy_ff, sqz_ff, s2_xz_ff, s2_y_ff;
   logic [csp_pkg::SQ_WIDTH-1:0] s3_all_ff, s3_xz_ff;

   always_comb begin
      s0_side_in.nx  = req_dir_x[W-1];
      s0_side_in.nz  = req_dir_z[W-1];
      s0_side_in.pos = !req_dir_y[W-1] && (req_dir_y != '0);
      // two's complement negate gives the exact magnitude of the most negative word
      s0_side_in.mx  = req_dir_x[W-1] ? (~req_dir_x + 1'b1) : req_dir_x;
      s0_side_in.my  = req_dir_y[W-1] ? (~req_dir_y + 1'b1) : req_dir_y;
      s0_side_in.mz  = req_dir_z[W-1] ? (~req_dir_z + 1'b1) : req_dir_z;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_side_ff <= s0_side_in;
         s1_side_ff <= s0_side_ff;
         sqx_ff     <= s0_side_ff.mx * s0_side_ff.mx;
         sqy_ff     <= s0_side_ff.my * s0_side_ff.my;
         sqz_ff     <= s0_side_ff.mz * s0_side_ff.mz;
         s2_side_ff <= s1_side_ff;
         s2_xz_ff   <= sqx_ff + sqz_ff;
         s2_y_ff    <= sqy_ff;
         s3_side_ff <= s2_side_ff;
         s3_all_ff  <= s2_xz_ff + s2_y_ff;
         s3_xz_ff   <= s2_xz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_valid;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // square root chain: norm n and radial length s
   csp_pkg::sqrt_lane_type n_lane [NS+1];
   csp_pkg::sqrt_lane_type s_lane [NS+1];
   csp_pkg::dir_side_type  sq_side [NS+1];
   csp_pkg::dir_side_type  sq_side_ff [NS];
   logic [NS:0]            sq_vld;
   logic [NS-1:0]          sq_vld_ff;

   assign n_lane[0]  = '{rad: s3_all_ff, rem: '0, root: '0};
   assign s_lane[0]  = '{rad: s3_xz_ff, rem: '0, root: '0};
   assign sq_side[0] = s3_side_ff;
   assign sq_vld[0]  = s3_vld_ff;

   for (genvar g = 0; g < NS; g++) begin : g_sqrt
      csp_sqrt_cell u_n (.clock(clock), .en(en), .src(n_lane[g]), .dst(n_lane[g+1]));
      csp_sqrt_cell u_s (.clock(clock), .en(en), .src(s_lane[g]), .dst(s_lane[g+1]));

      always_ff @(posedge clock) begin
         if (en) begin
            sq_side_ff[g] <= sq_side[g];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[g] <= 1'b0;
         end else if (en) begin
            sq_vld_ff[g] <= sq_vld[g];
         end
      end

      assign sq_side[g+1] = sq_side_ff[g];
      assign sq_vld[g+1]  = sq_vld_ff[g];
   end

   // products: threshold and rim numerators
   logic [csp_pkg::T_WIDTH-1:0]    t_ff;
   logic [csp_pkg::PROD_WIDTH-1:0] tx_ff, tz_ff;
   logic [csp_pkg::ROOT_WIDTH-1:0] s_ff;
   csp_pkg::dir_side_type          p1_side_ff;
   logic                           p1_vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff       <= n_lane[NS].root * sin_angle_ff;
         tx_ff      <= sq_side[NS].mx * bottom_radius_ff;
         tz_ff      <= sq_side[NS].mz * bottom_radius_ff;
         s_ff       <= s_lane[NS].root;
         p1_side_ff <= sq_side[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= sq_vld[NS];
      end
   end

   // feature decision feeds the divider chain
   logic                        apex;
   logic                        rim;
   logic [csp_pkg::FEAT_WIDTH-1:0] feat;

   always_comb begin
      apex = p1_side_ff.pos &&
             ({1'b0, p1_side_ff.my} > t_ff[csp_pkg::T_WIDTH-1:csp_pkg::FRAC_BITS]);
      rim  = s_ff > csp_pkg::ROOT_WIDTH'(epsilon_ff);
      if (apex) begin
         feat = csp_pkg::FEAT_APEX;
      end else if (rim) begin
         feat = csp_pkg::FEAT_RIM;
      end else begin
         feat = csp_pkg::FEAT_CENTRE;
      end
   end

   csp_pkg::div_lane_type x_lane [ND+1];
   csp_pkg::div_lane_type z_lane [ND+1];
   csp_pkg::div_side_type dv_side [ND+1];
   csp_pkg::div_side_type dv_side_ff [ND];
   logic [ND:0]           dv_vld;
   logic [ND-1:0]         dv_vld_ff;

   assign x_lane[0] = '{rem:  tx_ff[csp_pkg::PROD_WIDTH-1 -: csp_pkg::ROOT_WIDTH],
                        low:  tx_ff[csp_pkg::QUOT_WIDTH-1:0],
                        quot: '0};
   assign z_lane[0] = '{rem:  tz_ff[csp_pkg::PROD_WIDTH-1 -: csp_pkg::ROOT_WIDTH],
                        low:  tz_ff[csp_pkg::QUOT_WIDTH-1:0],
                        quot: '0};
   assign dv_side[0] = '{feature: feat, nx: p1_side_ff.nx, nz: p1_side_ff.nz, s: s_ff};
   assign dv_vld[0]  = p1_vld_ff;

   for (genvar g = 0; g < ND; g++) begin : g_div
      csp_div_cell u_x (.clock(clock), .en(en), .divisor(dv_side[g].s),
                        .src(x_lane[g]), .dst(x_lane[g+1]));
      csp_div_cell u_z (.clock(clock), .en(en), .divisor(dv_side[g].s),
                        .src(z_lane[g]), .dst(z_lane[g+1]));

      always_ff @(posedge clock) begin
         if (en) begin
            dv_side_ff[g] <= dv_side[g];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[g] <= 1'b0;
         end else if (en) begin
            dv_vld_ff[g] <= dv_vld[g];
         end
      end

      assign dv_side[g+1] = dv_side_ff[g];
      assign dv_vld[g+1]  = dv_vld_ff[g];
   end

   // result assembly
   logic [csp_pkg::QH_WIDTH+1:0] apex_y;
   logic [W-1:0]                 qx, qz;

   always_comb begin
      apex_y = {1'b0, quarter_height_ff, 1'b0} + {2'b00, quarter_height_ff};
      qx     = {1'b0, x_lane[ND].quot};
      qz     = {1'b0, z_lane[ND].quot};
      res.feature = dv_side[ND].feature;
      res.point_x = '0;
      res.point_z = '0;
      res.point_y = -(W'(quarter_height_ff));
      if (dv_side[ND].feature == csp_pkg::FEAT_APEX) begin
         // three quarter heights may pass the signed limit
         res.point_y = apex_y[csp_pkg::QH_WIDTH+1] ? csp_pkg::POS_MAX : W'(apex_y);
      end else if (dv_side[ND].feature == csp_pkg::FEAT_RIM) begin
         res.point_x = dv_side[ND].nx ? (~qx + 1'b1) : qx;
         res.point_z = dv_side[ND].nz ? (~qz + 1'b1) : qz;
      end
   end

   assign push = en && dv_vld[ND];

   csp_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (res),
      .pop_ready  (rsp_ready),
      .full       (buf_full),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_point_x = head.point_x;
   assign rsp_point_y = head.point_y;
   assign rsp_point_z = head.point_z;
   assign rsp_feature = head.feature;

   `CSP_ASSERT_NOW(a_apex_on_axis, rsp_valid && rsp_feature == csp_pkg::FEAT_APEX,
                   rsp_point_x == '0 && rsp_point_z == '0)
   `CSP_ASSERT_NOW(a_base_height, rsp_valid && rsp_feature != csp_pkg::FEAT_APEX,
                   rsp_point_y == -(W'(quarter_height_ff)))
   `CSP_ASSERT_NEXT(a_full_holds, !req_ready && !rsp_ready, !req_ready && rsp_valid)

endmodule
